[rtl/core/tgs_pkg.sv]
// Shared types and constants for the transmit gap statistics and activity LED block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package tgs_pkg;

    // Request codes carried in the req_type field.
    typedef enum logic [1:0] {
        REQ_TX   = 2'd0,
        REQ_LAT  = 2'd1,
        REQ_TIME = 2'd2
    } t_req;

    // Configuration register indexes.
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_WINDOW       = 3'd0;
    localparam t_cfg_idx CFG_BUSY_THR     = 3'd1;
    localparam t_cfg_idx CFG_MEDIUM_THR   = 3'd2;
    localparam t_cfg_idx CFG_LOW_THR      = 3'd3;
    localparam t_cfg_idx CFG_BUSY_IVL     = 3'd4;
    localparam t_cfg_idx CFG_MEDIUM_IVL   = 3'd5;
    localparam t_cfg_idx CFG_LOW_IVL      = 3'd6;
    localparam t_cfg_idx CFG_IDLE_IVL     = 3'd7;

    localparam int WINDOW_W = 20;
    localparam int CFG16_W  = 16;
    localparam int CFG_DATA_W = WINDOW_W;

    // Register values after reset.
    localparam logic [WINDOW_W-1:0] RST_WINDOW     = 20'd10000;
    localparam logic [CFG16_W-1:0]  RST_BUSY_THR   = 16'd50;
    localparam logic [CFG16_W-1:0]  RST_MEDIUM_THR = 16'd20;
    localparam logic [CFG16_W-1:0]  RST_LOW_THR    = 16'd5;
    localparam logic [CFG16_W-1:0]  RST_BUSY_IVL   = 16'd50;
    localparam logic [CFG16_W-1:0]  RST_MEDIUM_IVL = 16'd100;
    localparam logic [CFG16_W-1:0]  RST_LOW_IVL    = 16'd250;
    localparam logic [CFG16_W-1:0]  RST_IDLE_IVL   = 16'd500;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic prep;
        logic upd;
        logic div_start;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic report_due;
        logic events_nz;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_sts;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_UPD  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_ctrl_state;

endpackage

[rtl/core/tgs_div.sv]
// Restoring divider, one quotient bit per cycle, for the average gap.
// Divides a 64-bit total by a 32-bit count and keeps the low 32 quotient bits.
`timescale 1ns / 1ps

module tgs_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_quot
);

    localparam int STEPS = 64;
    localparam logic [5:0] LAST_CNT = 6'(STEPS - 1);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [63:0] r_quo;
    logic [31:0] r_div;

    logic [32:0] w_shift;
    logic        w_ge;
    logic [32:0] w_diff;

    // One trial subtraction per cycle.
    assign w_shift = {r_rem, r_quo[63]};
    assign w_ge    = w_shift >= {1'b0, r_div};
    assign w_diff  = w_shift - {1'b0, r_div};

    // Control: step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= LAST_CNT;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[31:0] : w_shift[31:0];
            r_quo <= {r_quo[62:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo[31:0];

endmodule

[rtl/core/tgs_ctrl.sv]
// Controller state machine for the gap statistics block.
// Sequences accept, prepare, update, divide and output; uses tgs_pkg.
`timescale 1ns / 1ps

module tgs_ctrl
    import tgs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                if (i_sts.report_due && i_sts.events_nz) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

[rtl/core/tgs_dp.sv]
// Datapath of the gap statistics block: configuration, statistics, LED and output register.
// Driven by commands from tgs_ctrl; instantiates tgs_div and uses tgs_pkg.
`timescale 1ns / 1ps

module tgs_dp
    import tgs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]            i_req_type,
    input  logic [63:0]           i_event_time_us,
    input  logic [31:0]           i_latency_us,
    input  logic [31:0]           i_now_ms,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic                  o_led_on,
    output logic                  o_report_valid,
    output logic [31:0]           o_gap_max_us,
    output logic [31:0]           o_gap_avg_us,
    output logic [31:0]           o_gap_count,
    output logic [31:0]           o_latency_max_us,
    output logic [31:0]           o_latency_last_us
);

    // Configuration registers.
    logic [WINDOW_W-1:0] r_window;
    logic [CFG16_W-1:0]  r_busy_thr;
    logic [CFG16_W-1:0]  r_medium_thr;
    logic [CFG16_W-1:0]  r_low_thr;
    logic [CFG16_W-1:0]  r_busy_ivl;
    logic [CFG16_W-1:0]  r_medium_ivl;
    logic [CFG16_W-1:0]  r_low_ivl;
    logic [CFG16_W-1:0]  r_idle_ivl;

    // Captured item.
    logic [1:0]  r_req;
    logic [63:0] r_stamp;
    logic [31:0] r_lat;
    logic [31:0] r_now;

    // Prepared differences.
    logic [31:0] r_gap;
    logic [31:0] r_recent;
    logic [31:0] r_tog_el;
    logic [31:0] r_win_el;

    // Statistics state.
    logic [63:0] r_last_stamp;
    logic        r_tx_seen;
    logic [31:0] r_gap_peak;
    logic [63:0] r_gap_total;
    logic [31:0] r_gap_events;
    logic [31:0] r_lat_peak;
    logic [31:0] r_lat_recent;
    logic        r_led;
    logic [31:0] r_last_toggle;
    logic [31:0] r_last_report;
    logic [31:0] r_snapshot;

    // Report held until the output register takes it.
    logic        r_rep_valid;
    logic        r_rep_nz;
    logic [31:0] r_rep_gmax;
    logic [31:0] r_rep_count;
    logic [31:0] r_rep_lmax;
    logic [31:0] r_rep_llast;

    // Output register.
    logic        r_out_valid;
    logic        r_out_led;
    logic        r_out_rep;
    logic [31:0] r_out_gmax;
    logic [31:0] r_out_gavg;
    logic [31:0] r_out_count;
    logic [31:0] r_out_lmax;
    logic [31:0] r_out_llast;

    logic        w_is_time;
    logic        w_report_due;
    logic        w_toggle_due;
    logic [15:0] w_interval;
    logic        w_div_busy;
    logic        w_div_done;
    logic [31:0] w_div_quot;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window     <= RST_WINDOW;
            r_busy_thr   <= RST_BUSY_THR;
            r_medium_thr <= RST_MEDIUM_THR;
            r_low_thr    <= RST_LOW_THR;
            r_busy_ivl   <= RST_BUSY_IVL;
            r_medium_ivl <= RST_MEDIUM_IVL;
            r_low_ivl    <= RST_LOW_IVL;
            r_idle_ivl   <= RST_IDLE_IVL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WINDOW:     r_window     <= i_cfg_data;
                CFG_BUSY_THR:   r_busy_thr   <= i_cfg_data[CFG16_W-1:0];
                CFG_MEDIUM_THR: r_medium_thr <= i_cfg_data[CFG16_W-1:0];
                CFG_LOW_THR:    r_low_thr    <= i_cfg_data[CFG16_W-1:0];
                CFG_BUSY_IVL:   r_busy_ivl   <= i_cfg_data[CFG16_W-1:0];
                CFG_MEDIUM_IVL: r_medium_ivl <= i_cfg_data[CFG16_W-1:0];
                CFG_LOW_IVL:    r_low_ivl    <= i_cfg_data[CFG16_W-1:0];
                CFG_IDLE_IVL:   r_idle_ivl   <= i_cfg_data[CFG16_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input capture and the differences that the update step needs.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req   <= i_req_type;
            r_stamp <= i_event_time_us;
            r_lat   <= i_latency_us;
            r_now   <= i_now_ms;
        end
        if (i_cmd.prep) begin
            r_gap    <= r_stamp[31:0] - r_last_stamp[31:0];
            r_recent <= r_gap_events - r_snapshot;
            r_tog_el <= r_now - r_last_toggle;
            r_win_el <= r_now - r_last_report;
        end
    end

    // Blink interval from the gap count since the last toggle.
    always_comb begin
        if (r_recent > {16'd0, r_busy_thr}) begin
            w_interval = r_busy_ivl;
        end else if (r_recent > {16'd0, r_medium_thr}) begin
            w_interval = r_medium_ivl;
        end else if (r_recent > {16'd0, r_low_thr}) begin
            w_interval = r_low_ivl;
        end else begin
            w_interval = r_idle_ivl;
        end
    end

    assign w_is_time    = (r_req == REQ_TIME);
    assign w_toggle_due = w_is_time && (r_tog_el >= {16'd0, w_interval});
    assign w_report_due = w_is_time && (r_win_el >= {12'd0, r_window});

    // Statistics, LED and window update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_stamp  <= '0;
            r_tx_seen     <= 1'b0;
            r_gap_peak    <= '0;
            r_gap_total   <= '0;
            r_gap_events  <= '0;
            r_lat_peak    <= '0;
            r_lat_recent  <= '0;
            r_led         <= 1'b0;
            r_last_toggle <= '0;
            r_last_report <= '0;
            r_snapshot    <= '0;
        end else if (i_cmd.upd) begin
            case (r_req)
                REQ_TX: begin
                    if (r_tx_seen) begin
                        if (r_gap > r_gap_peak) begin
                            r_gap_peak <= r_gap;
                        end
                        r_gap_total  <= r_gap_total + {32'd0, r_gap};
                        r_gap_events <= r_gap_events + 32'd1;
                    end
                    r_last_stamp <= r_stamp;
                    r_tx_seen    <= 1'b1;
                end
                REQ_LAT: begin
                    r_lat_recent <= r_lat;
                    if (r_lat > r_lat_peak) begin
                        r_lat_peak <= r_lat;
                    end
                end
                REQ_TIME: begin
                    if (w_toggle_due) begin
                        r_last_toggle <= r_now;
                        r_led         <= ~r_led;
                        r_snapshot    <= r_gap_events;
                    end
                    // Window end clears the peaks, the gap total and count, and the toggle snapshot.
                    if (w_report_due) begin
                        r_last_report <= r_now;
                        r_gap_peak    <= '0;
                        r_gap_total   <= '0;
                        r_gap_events  <= '0;
                        r_lat_peak    <= '0;
                        r_snapshot    <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Report snapshot taken before the window is cleared.
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_rep_valid <= w_report_due;
            r_rep_nz    <= w_report_due && (r_gap_events != '0);
            r_rep_gmax  <= w_report_due ? r_gap_peak   : '0;
            r_rep_count <= w_report_due ? r_gap_events : '0;
            r_rep_lmax  <= w_report_due ? r_lat_peak   : '0;
            r_rep_llast <= w_report_due ? r_lat_recent : '0;
        end
    end

    tgs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_gap_total),
        .i_divisor  (r_gap_events),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // Output register: loaded when free, cleared when the item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_led   <= r_led;
            r_out_rep   <= r_rep_valid;
            r_out_gmax  <= r_rep_gmax;
            r_out_gavg  <= r_rep_nz ? w_div_quot : '0;
            r_out_count <= r_rep_count;
            r_out_lmax  <= r_rep_lmax;
            r_out_llast <= r_rep_llast;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_sts.report_due = w_report_due;
        o_sts.events_nz  = (r_gap_events != '0);
        o_sts.div_busy   = w_div_busy;
        o_sts.div_done   = w_div_done;
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid       = r_out_valid;
    assign o_led_on          = r_out_led;
    assign o_report_valid    = r_out_rep;
    assign o_gap_max_us      = r_out_gmax;
    assign o_gap_avg_us      = r_out_gavg;
    assign o_gap_count       = r_out_count;
    assign o_latency_max_us  = r_out_lmax;
    assign o_latency_last_us = r_out_llast;

endmodule

[rtl/core/tx_gap_stats_activity_led.sv]
// Transmit gap statistics with activity LED, top level.
// An item without a window report passes the prepare, update and done states on its way
// to the output register; no new item is taken until the controller is back in idle.
// A window report with gaps counted also waits in the divide state for the 64-step average.
// A full output register holds the next result back; synchronous active-low reset restores
// the register defaults and clears all statistics. Uses tgs_ctrl, tgs_dp and tgs_pkg.
`timescale 1ns / 1ps

module tx_gap_stats_activity_led
    import tgs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_req_type,
    input  logic [63:0]           i_event_time_us,
    input  logic [31:0]           i_latency_us,
    input  logic [31:0]           i_now_ms,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_led_on,
    output logic                  o_report_valid,
    output logic [31:0]           o_gap_max_us,
    output logic [31:0]           o_gap_avg_us,
    output logic [31:0]           o_gap_count,
    output logic [31:0]           o_latency_max_us,
    output logic [31:0]           o_latency_last_us
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencing.
    tgs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // Statistics, LED and output register.
    tgs_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_req_type        (i_req_type),
        .i_event_time_us   (i_event_time_us),
        .i_latency_us      (i_latency_us),
        .i_now_ms          (i_now_ms),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_led_on          (o_led_on),
        .o_report_valid    (o_report_valid),
        .o_gap_max_us      (o_gap_max_us),
        .o_gap_avg_us      (o_gap_avg_us),
        .o_gap_count       (o_gap_count),
        .o_latency_max_us  (o_latency_max_us),
        .o_latency_last_us (o_latency_last_us)
    );

    // An accepted item blocks the input until its work is done.
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while an item was still in work");

    // A result without a report carries zero report fields.
    a_no_report_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_report_valid) |->
            (o_gap_max_us == '0) && (o_gap_avg_us == '0) && (o_gap_count == '0) &&
            (o_latency_max_us == '0) && (o_latency_last_us == '0))
        else $error("report fields set without a report");

    // Starting a division leaves the divider busy on the next cycle.
    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |=> w_sts.div_busy)
        else $error("divider did not start");

    // The output register is never loaded while the divider still runs.
    a_load_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !w_sts.div_busy)
        else $error("result loaded before the average was ready");

endmodule

[sim/tb_tx_gap_stats_activity_led.sv]
// Self-checking testbench for the transmit gap statistics and activity LED block.
// Drives items with random idling and backpressure; checks typed directed rows against their
// table, all else against a cycle-free statistics predictor. Uses tgs_pkg and the top only.
`timescale 1ns / 1ps

module tb_tx_gap_stats_activity_led
    import tgs_pkg::*;
();

    // Request code that the block must ignore apart from echoing the LED level.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Longest run of cycles with no item moving on either side before the run is abandoned.
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    // Length of the long receiver hold that fills the block up.
    localparam int unsigned HOLD_CYCLES = 400;
    // Cycles to let pass after the last result before the verdict.
    localparam int unsigned END_SETTLE = 80;

    // One result item of the block.
    typedef struct packed {
        logic        led_on;
        logic        report_valid;
        logic [31:0] gap_max_us;
        logic [31:0] gap_avg_us;
        logic [31:0] gap_count;
        logic [31:0] latency_max_us;
        logic [31:0] latency_last_us;
    } t_led_report;

    // One row of the directed stimulus table.
    typedef struct packed {
        logic [1:0]  req;
        logic [63:0] stamp;
        logic [31:0] lat;
        logic [31:0] now;
        logic        typed;
        logic        exp_led;
    } t_probe;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [2:0]            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [1:0]            i_req_type;
    logic [63:0]           i_event_time_us;
    logic [31:0]           i_latency_us;
    logic [31:0]           i_now_ms;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_led_on;
    logic                  o_report_valid;
    logic [31:0]           o_gap_max_us;
    logic [31:0]           o_gap_avg_us;
    logic [31:0]           o_gap_count;
    logic [31:0]           o_latency_max_us;
    logic [31:0]           o_latency_last_us;

    tx_gap_stats_activity_led u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_event_time_us   (i_event_time_us),
        .i_latency_us      (i_latency_us),
        .i_now_ms          (i_now_ms),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_led_on          (o_led_on),
        .o_report_valid    (o_report_valid),
        .o_gap_max_us      (o_gap_max_us),
        .o_gap_avg_us      (o_gap_avg_us),
        .o_gap_count       (o_gap_count),
        .o_latency_max_us  (o_latency_max_us),
        .o_latency_last_us (o_latency_last_us)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of the configuration registers.
    logic [WINDOW_W-1:0] set_window     = RST_WINDOW;
    logic [CFG16_W-1:0]  set_busy_thr   = RST_BUSY_THR;
    logic [CFG16_W-1:0]  set_medium_thr = RST_MEDIUM_THR;
    logic [CFG16_W-1:0]  set_low_thr    = RST_LOW_THR;
    logic [CFG16_W-1:0]  set_busy_ivl   = RST_BUSY_IVL;
    logic [CFG16_W-1:0]  set_medium_ivl = RST_MEDIUM_IVL;
    logic [CFG16_W-1:0]  set_low_ivl    = RST_LOW_IVL;
    logic [CFG16_W-1:0]  set_idle_ivl   = RST_IDLE_IVL;

    // Predictor copy of the statistics and LED state.
    logic        seen_tx       = 1'b0;
    logic [63:0] prev_stamp    = '0;
    logic [31:0] win_gap_max   = '0;
    logic [63:0] win_gap_sum   = '0;
    logic [31:0] win_gap_cnt   = '0;
    logic [31:0] win_lat_max   = '0;
    logic [31:0] lat_now       = '0;
    logic        led_q         = 1'b0;
    logic [31:0] toggle_ms     = '0;
    logic [31:0] report_ms     = '0;
    logic [31:0] cnt_at_toggle = '0;

    // Results still owed by the block, oldest first.
    t_led_report led_report_q[$];
    t_probe      probe_tab[$];

    // Expectation typed into the directed table for the item now offered.
    logic        cur_typed = 1'b0;
    t_led_report cur_exp   = '0;

    logic        idle_on     = 1'b1;
    int unsigned hold_asks   = 0;
    int unsigned hold_served = 0;
    int unsigned fail_count  = 0;
    int unsigned quiet_cycles = 0;
    logic [63:0] stamp_now   = '0;
    logic [31:0] ms_now      = '0;

    // Blink interval chosen from the gaps counted since the last toggle.
    function automatic logic [15:0] blink_interval(input logic [31:0] since);
        if (since > {16'd0, set_busy_thr})
            return set_busy_ivl;
        if (since > {16'd0, set_medium_thr})
            return set_medium_ivl;
        if (since > {16'd0, set_low_thr})
            return set_low_ivl;
        return set_idle_ivl;
    endfunction

    // Advances the predicted state by one item and returns the result it causes.
    function automatic t_led_report traffic_step(input logic [1:0] req,
            input logic [63:0] stamp, input logic [31:0] lat, input logic [31:0] now);
        t_led_report r;
        logic [63:0] diff;
        logic [63:0] mean;
        logic [31:0] span;
        r = '0;
        case (req)
            REQ_TX: begin
                // The first transmit only stores its timestamp.
                if (seen_tx) begin
                    diff = stamp - prev_stamp;
                    if (diff[31:0] > win_gap_max)
                        win_gap_max = diff[31:0];
                    win_gap_sum = win_gap_sum + {32'd0, diff[31:0]};
                    win_gap_cnt = win_gap_cnt + 32'd1;
                end
                prev_stamp = stamp;
                seen_tx    = 1'b1;
            end
            REQ_LAT: begin
                lat_now = lat;
                if (lat > win_lat_max)
                    win_lat_max = lat;
            end
            REQ_TIME: begin
                // LED first, then the report window; both use wrapping differences.
                span = now - toggle_ms;
                if (span >= {16'd0, blink_interval(win_gap_cnt - cnt_at_toggle)}) begin
                    toggle_ms     = now;
                    led_q         = ~led_q;
                    cnt_at_toggle = win_gap_cnt;
                end
                span = now - report_ms;
                if (span >= {12'd0, set_window}) begin
                    report_ms = now;
                    mean = '0;
                    if (win_gap_cnt != 32'd0)
                        mean = win_gap_sum / {32'd0, win_gap_cnt};
                    r.report_valid    = 1'b1;
                    r.gap_max_us      = win_gap_max;
                    r.gap_avg_us      = mean[31:0];
                    r.gap_count       = win_gap_cnt;
                    r.latency_max_us  = win_lat_max;
                    r.latency_last_us = lat_now;
                    win_gap_max   = '0;
                    win_gap_sum   = '0;
                    win_gap_cnt   = '0;
                    win_lat_max   = '0;
                    cnt_at_toggle = '0;
                end
            end
            default: ;
        endcase
        r.led_on = led_q;
        return r;
    endfunction

    task automatic show_mismatch(input string what, input t_led_report e,
            input t_led_report a);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t %s", $realtime, what);
            $display("  expected led=%0b rpt=%0b max=%h avg=%h cnt=%h lmax=%h llast=%h",
                e.led_on, e.report_valid, e.gap_max_us, e.gap_avg_us, e.gap_count,
                e.latency_max_us, e.latency_last_us);
            $display("  actual   led=%0b rpt=%0b max=%h avg=%h cnt=%h lmax=%h llast=%h",
                a.led_on, a.report_valid, a.gap_max_us, a.gap_avg_us, a.gap_count,
                a.latency_max_us, a.latency_last_us);
        end
    endtask

    // Predicts on every accepted item and checks every accepted result.
    always @(posedge i_clk) begin : scoreboard
        t_led_report calc_r;
        t_led_report seen_r;
        t_led_report want_r;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                calc_r = traffic_step(i_req_type, i_event_time_us, i_latency_us, i_now_ms);
                led_report_q.push_back(cur_typed ? cur_exp : calc_r);
            end
            if (o_out_valid && !i_out_stall) begin
                seen_r.led_on          = o_led_on;
                seen_r.report_valid    = o_report_valid;
                seen_r.gap_max_us      = o_gap_max_us;
                seen_r.gap_avg_us      = o_gap_avg_us;
                seen_r.gap_count       = o_gap_count;
                seen_r.latency_max_us  = o_latency_max_us;
                seen_r.latency_last_us = o_latency_last_us;
                if (led_report_q.size() == 0) begin
                    show_mismatch("result with nothing expected", '0, seen_r);
                end else begin
                    want_r = led_report_q.pop_front();
                    if (want_r !== seen_r)
                        show_mismatch("result mismatch", want_r, seen_r);
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: random stall bursts, plus one long hold on request.
    initial begin : receiver
        int unsigned burst;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_asks != hold_served) begin
                hold_served++;
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 10);
                i_out_stall = 1'b1;
                repeat (burst) @(negedge i_clk);
                i_out_stall = 1'b0;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    // Offers one item from a falling edge and returns at the falling edge after acceptance.
    task automatic send_item(input logic [1:0] req, input logic [63:0] stamp,
            input logic [31:0] lat, input logic [31:0] now, input logic typed,
            input t_led_report exp);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_req_type      = req;
        i_event_time_us = stamp;
        i_latency_us    = lat;
        i_now_ms        = now;
        cur_typed       = typed;
        cur_exp         = exp;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drops valid and waits until every owed result has come back.
    task automatic drain(input int unsigned settle);
        i_in_valid = 1'b0;
        while (led_report_q.size() != 0)
            @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        case (idx)
            CFG_WINDOW:     set_window     = data[WINDOW_W-1:0];
            CFG_BUSY_THR:   set_busy_thr   = data[CFG16_W-1:0];
            CFG_MEDIUM_THR: set_medium_thr = data[CFG16_W-1:0];
            CFG_LOW_THR:    set_low_thr    = data[CFG16_W-1:0];
            CFG_BUSY_IVL:   set_busy_ivl   = data[CFG16_W-1:0];
            CFG_MEDIUM_IVL: set_medium_ivl = data[CFG16_W-1:0];
            CFG_LOW_IVL:    set_low_ivl    = data[CFG16_W-1:0];
            CFG_IDLE_IVL:   set_idle_ivl   = data[CFG16_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic load_settings(input logic [19:0] win, input logic [19:0] bt,
            input logic [19:0] mt, input logic [19:0] lt, input logic [19:0] bi,
            input logic [19:0] mi, input logic [19:0] li, input logic [19:0] ii);
        cfg_write(CFG_WINDOW, win);
        cfg_write(CFG_BUSY_THR, bt);
        cfg_write(CFG_MEDIUM_THR, mt);
        cfg_write(CFG_LOW_THR, lt);
        cfg_write(CFG_BUSY_IVL, bi);
        cfg_write(CFG_MEDIUM_IVL, mi);
        cfg_write(CFG_LOW_IVL, li);
        cfg_write(CFG_IDLE_IVL, ii);
    endtask

    task automatic add_probe(input logic [1:0] req, input logic [63:0] stamp,
            input logic [31:0] lat, input logic [31:0] now, input logic typed,
            input logic exp_led);
        t_probe p;
        p.req     = req;
        p.stamp   = stamp;
        p.lat     = lat;
        p.now     = now;
        p.typed   = typed;
        p.exp_led = exp_led;
        probe_tab.push_back(p);
    endtask

    // Random traffic: bursts of transmits with stray latency samples, closed by a
    // time update; a little noise with the unused request code.
    task automatic run_phase(input int unsigned budget, input int unsigned ms_span);
        int unsigned given;
        int unsigned n_tx;
        int unsigned k;
        logic [31:0] lat;
        given = 0;
        while (given < budget) begin
            case ($urandom_range(0, 7))
                0, 1, 2, 3: n_tx = $urandom_range(0, 2);
                4, 5:       n_tx = $urandom_range(3, 10);
                6:          n_tx = $urandom_range(10, 30);
                default:    n_tx = $urandom_range(30, 70);
            endcase
            for (k = 0; k < n_tx; k++) begin
                if ($urandom_range(0, 29) == 0)
                    send_item(REQ_UNUSED, {$urandom, $urandom}, $urandom, $urandom,
                        1'b0, '0);
                case ($urandom_range(0, 19))
                    0:       stamp_now = {$urandom, $urandom};
                    1:       ;
                    default: stamp_now = stamp_now + 64'($urandom_range(1, 5000));
                endcase
                send_item(REQ_TX, stamp_now, $urandom, $urandom, 1'b0, '0);
                given++;
                if ($urandom_range(0, 9) == 0) begin
                    lat = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 2000);
                    send_item(REQ_LAT, {$urandom, $urandom}, lat, $urandom, 1'b0, '0);
                    given++;
                end
            end
            case ($urandom_range(0, 9))
                0:       ms_now = $urandom;
                1:       ;
                2:       ms_now = ms_now + $urandom_range(0, 1 << 20);
                default: ms_now = ms_now + $urandom_range(0, ms_span);
            endcase
            send_item(REQ_TIME, {$urandom, $urandom}, $urandom, ms_now, 1'b0, '0);
            given++;
        end
    endtask

    initial begin : stimulus
        logic [19:0] win;
        logic [19:0] lt;
        logic [19:0] mt;
        logic [19:0] bt;
        t_led_report exp;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_req_type      = REQ_TX;
        i_event_time_us = '0;
        i_latency_us    = '0;
        i_now_ms        = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part under the reset settings: first transmit at zero, extreme
        // timestamps with a wrapping gap, a repeated stamp, latency extremes, the unused
        // code, the first LED toggle, reports with and without gaps, and ms wrap.
        add_probe(REQ_TIME, '0, '0, 32'd0, 1'b1, 1'b0);
        add_probe(REQ_TX, 64'd0, '0, '0, 1'b1, 1'b0);
        add_probe(REQ_TX, '1, '0, '0, 1'b1, 1'b0);
        add_probe(REQ_TX, 64'h0000_0001_0000_0005, '0, '0, 1'b1, 1'b0);
        add_probe(REQ_LAT, '0, 32'hFFFF_FFFF, '0, 1'b1, 1'b0);
        add_probe(REQ_LAT, '0, 32'd0, '0, 1'b1, 1'b0);
        add_probe(REQ_LAT, '0, 32'h5A5A_A5A5, '0, 1'b1, 1'b0);
        add_probe(REQ_UNUSED, '1, '1, '1, 1'b1, 1'b0);
        add_probe(REQ_TIME, '0, '0, 32'd499, 1'b1, 1'b0);
        add_probe(REQ_TIME, '0, '0, 32'd500, 1'b1, 1'b1);
        add_probe(REQ_TX, 64'h0000_0001_0000_0005, '0, '0, 1'b0, 1'b0);
        add_probe(REQ_TIME, '0, '0, 32'd10000, 1'b0, 1'b0);
        add_probe(REQ_TIME, '0, '0, 32'd10001, 1'b0, 1'b0);
        add_probe(REQ_LAT, '0, 32'h0000_0001, '0, 1'b0, 1'b0);
        add_probe(REQ_TIME, '0, '0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        add_probe(REQ_TIME, '0, '0, 32'd5, 1'b0, 1'b0);
        add_probe(REQ_TX, 64'hA5A5_5A5A_0F0F_F0F0, '0, '0, 1'b0, 1'b0);
        add_probe(REQ_TX, 64'h5A5A_A5A5_F0F0_0F10, '0, '0, 1'b0, 1'b0);
        add_probe(REQ_TIME, '0, '0, 32'd10010, 1'b0, 1'b0);
        foreach (probe_tab[i]) begin
            exp        = '0;
            exp.led_on = probe_tab[i].exp_led;
            send_item(probe_tab[i].req, probe_tab[i].stamp, probe_tab[i].lat,
                probe_tab[i].now, probe_tab[i].typed, exp);
        end
        stamp_now = 64'hA5A5_5A5A_F0F0_0F10;
        ms_now    = 32'd10010;

        // Smallest legal settings: every gap counts as busy traffic.
        drain(8);
        load_settings(20'd1, 20'd0, 20'd0, 20'd0, 20'd1, 20'd1, 20'd1, 20'd1);
        run_phase(210, 2);

        // Zero window and intervals, with upper data bits that must be masked off.
        drain(8);
        load_settings(20'd0, 20'hF0000, 20'hF0000, 20'hF0000, 20'hF0000, 20'hF0000,
            20'hF0000, 20'hF0000);
        run_phase(210, 2);

        // Moderate random settings; the receiver holds off long enough to back up input.
        drain(8);
        win = 20'($urandom_range(50, 2000));
        lt  = 20'($urandom_range(0, 5));
        mt  = lt + 20'($urandom_range(1, 15));
        bt  = mt + 20'($urandom_range(1, 30));
        load_settings(win, bt, mt, lt, 20'($urandom_range(1, 300)),
            20'($urandom_range(1, 300)), 20'($urandom_range(1, 300)),
            20'($urandom_range(1, 300)));
        hold_asks++;
        run_phase(210, win / 2 + 1);

        // Largest settings.
        drain(8);
        load_settings(20'hFFFFF, 20'h0FFFF, 20'h0FFFF, 20'h0FFFF, 20'h0FFFF, 20'h0FFFF,
            20'h0FFFF, 20'h0FFFF);
        run_phase(210, 200000);

        // Fully random register data.
        drain(8);
        load_settings(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)),
            20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)),
            20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)),
            20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)));
        run_phase(210, 50000);

        // Reset values again, with both sides running at full rate.
        drain(8);
        idle_on = 1'b0;
        load_settings(RST_WINDOW, 20'(RST_BUSY_THR), 20'(RST_MEDIUM_THR), 20'(RST_LOW_THR),
            20'(RST_BUSY_IVL), 20'(RST_MEDIUM_IVL), 20'(RST_LOW_IVL), 20'(RST_IDLE_IVL));
        run_phase(200, 3000);

        drain(END_SETTLE);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/tgs_pkg.sv
rtl/core/tgs_div.sv
rtl/core/tgs_ctrl.sv
rtl/core/tgs_dp.sv
rtl/core/tx_gap_stats_activity_led.sv
sim/tb_tx_gap_stats_activity_led.sv
